### rtl/core/ssdf_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set difference filter package
// Shared types and command codes for the merge anti-join core.
// ----------------------------------------------------------------------------
package ssdf_pkg;

    localparam int TERM_W  = 64;
    localparam int INDEX_W = 12;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Contents of one look-ahead cell.
    typedef struct packed {
        logic              valid;
        logic [TERM_W-1:0] value;
    } cell_t;

    // Control that every cell of the look-ahead chain sees.
    typedef struct packed {
        logic flush;
        logic pop;
        logic push;
    } chain_ctl_t;

endpackage

### rtl/core/ssdf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/ssdf_cell.sv
// ----------------------------------------------------------------------------
// Look-ahead cell
// One stage of the compacting chain that holds upcoming old-set terms.
// ----------------------------------------------------------------------------
module ssdf_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssdf_pkg::chain_ctl_t          ctl,
    input  logic [ssdf_pkg::TERM_W-1:0]   push_value,
    input  ssdf_pkg::cell_t               left,
    input  ssdf_pkg::cell_t               right,
    output ssdf_pkg::cell_t               state
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ssdf_pkg::TERM_W-1:0] value_reg;
    logic [ssdf_pkg::TERM_W-1:0] value_next;
    logic                        after_valid;
    logic [ssdf_pkg::TERM_W-1:0] after_value;
    logic                        left_after_valid;
    logic                        take;

    // On a pop every cell takes its right neighbor's contents. A new term
    // lands in the first cell that is empty once the pop has happened.
    always_comb
    begin
        after_valid      = ctl.pop ? right.valid : valid_reg;
        after_value      = ctl.pop ? right.value : value_reg;
        left_after_valid = ctl.pop ? valid_reg : left.valid;
        take             = ctl.push && !after_valid && left_after_valid;
        valid_next       = !ctl.flush && (after_valid || take);
        value_next       = take ? push_value : after_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign state.valid = valid_reg;
    assign state.value = value_reg;

endmodule

### rtl/core/sorted_set_difference_filter_core.sv
// ----------------------------------------------------------------------------
// Sorted set difference filter core
// Merge anti-join: keeps ascending new terms that are absent from the old set.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                  Contents
//  s_*       in         s_tvalid/s_tready        tuser = cmd, tdata = term_value
//  m_*       out        m_tvalid/m_tready        tdata = retained_value, index
//  cfg_*     in         cfg_we                   cfg_wdata = stop_after_first
//
//  A load request, a clear request, an ignored command and a probe that
//  arrives after emission has stopped leave the sequencer idle. A probe
//  request enters the scan state, where the read pointer moves past smaller
//  old terms and the look-ahead chain (four cells by default) may wait on
//  the store's read port, until the probe is decided and any result is taken.
//  Reset is asynchronous and clears all control state; the old store itself
//  is not cleared and needs no clearing pass, since only written entries are
//  ever read. A result waiting on m_tready does not block further requests;
//  only a probe that must emit while the output register is full waits.
//
module sorted_set_difference_filter_core #(
    parameter int OLD_DEPTH = 4096,
    parameter int WINDOW    = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_wdata,      // stop_after_first

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,        // [63:0] term_value
    input  logic [1:0]  s_tuser,        // [1:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata         // [63:0] retained_value,
                                        // [75:64] retained_index, [79:76] zero
);

    localparam int AW = $clog2(OLD_DEPTH);
    localparam int CW = $clog2(OLD_DEPTH + 1);
    localparam int OW = $clog2(WINDOW + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ssdf_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 ptr_reg, ptr_next;
    logic [CW-1:0]                 fptr_reg, fptr_next;
    logic [OW-1:0]                 occ_reg, occ_next;
    logic                          inflight_reg, inflight_next;
    logic [ssdf_pkg::TERM_W-1:0]   probe_reg, probe_next;
    logic [ssdf_pkg::TERM_W-1:0]   last_reg, last_next;
    logic                          have_reg, have_next;
    logic                          stopped_reg, stopped_next;
    logic [ssdf_pkg::INDEX_W-1:0]  rcount_reg, rcount_next;
    logic                          stop_cfg_reg, stop_cfg_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ssdf_pkg::TERM_W-1:0]   m_value_reg, m_value_next;
    logic [ssdf_pkg::INDEX_W-1:0]  m_index_reg, m_index_next;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic           accept;
    ssdf_pkg::cmd_t cmd;
    logic           do_load;
    logic           do_clear;
    logic           do_probe;
    logic           store_full;

    assign accept     = s_tvalid && s_tready;
    assign cmd        = ssdf_pkg::cmd_t'(s_tuser);
    assign store_full = !(count_reg < CW'(OLD_DEPTH));

    always_comb
    begin
        do_load  = 1'b0;
        do_clear = 1'b0;
        do_probe = 1'b0;
        unique case (cmd)
            ssdf_pkg::CMD_LOAD:  do_load  = accept && !store_full;
            ssdf_pkg::CMD_CLEAR: do_clear = accept;
            ssdf_pkg::CMD_PROBE: do_probe = accept && !stopped_reg;
            default:             ;
        endcase
    end

    // ------------------------------------------------------------------
    // Old store and look-ahead chain
    // The chain holds the old terms from the read pointer onward, in order.
    // The fetch pointer runs ahead of the read pointer by the number of
    // valid cells plus the one read that may be in flight.
    // ------------------------------------------------------------------
    logic                        issue;
    logic [ssdf_pkg::TERM_W-1:0] rd_data;
    logic                        pop;
    ssdf_pkg::chain_ctl_t        chain_ctl;
    ssdf_pkg::cell_t             cells [WINDOW];
    logic [OW:0]                 pending;

    assign pending = {1'b0, occ_reg} + (OW + 1)'(inflight_reg);
    assign issue   = !do_clear && (fptr_reg < count_reg) &&
                     (pending < (OW + 1)'(WINDOW));

    ssdf_ram #(
        .WIDTH (ssdf_pkg::TERM_W),
        .DEPTH (OLD_DEPTH)
    ) u_old_store (
        .clk     (clk),
        .wr_en   (do_load),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (issue),
        .rd_addr (fptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign chain_ctl.flush = do_clear;
    assign chain_ctl.pop   = pop;
    assign chain_ctl.push  = inflight_reg;

    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        ssdf_pkg::cell_t left_in;
        ssdf_pkg::cell_t right_in;

        // The head has no left neighbor; it counts as filled so that a new
        // term lands there when the chain is empty.
        if (k == 0)
        begin : g_head
            assign left_in = '{valid: 1'b1, value: '0};
        end
        else
        begin : g_body
            assign left_in = cells[k-1];
        end

        if (k == WINDOW - 1)
        begin : g_tail
            assign right_in = '{valid: 1'b0, value: '0};
        end
        else
        begin : g_inner
            assign right_in = cells[k+1];
        end

        ssdf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (chain_ctl),
            .push_value (rd_data),
            .left       (left_in),
            .right      (right_in),
            .state      (cells[k])
        );
    end

    // ------------------------------------------------------------------
    // Merge step on the head of the chain
    // ------------------------------------------------------------------
    logic exhausted;
    logic head_less;
    logic head_equal;
    logic decide;
    logic duplicate;
    logic emit_want;
    logic out_free;
    logic done;
    logic emit;

    assign exhausted  = !(ptr_reg < count_reg);
    assign head_less  = cells[0].value < probe_reg;
    assign head_equal = cells[0].value == probe_reg;
    assign decide     = exhausted || (cells[0].valid && !head_less);
    assign duplicate  = have_reg && (last_reg == probe_reg);
    assign emit_want  = decide && !(!exhausted && head_equal) && !duplicate;
    assign out_free   = !m_valid_reg || m_tready;
    assign done       = decide && (!emit_want || out_free);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssdf_pkg::ST_IDLE:
            begin
                if (do_probe)
                begin
                    state_next = ssdf_pkg::ST_SCAN;
                end
            end
            ssdf_pkg::ST_SCAN:
            begin
                if (done)
                begin
                    state_next = ssdf_pkg::ST_IDLE;
                end
            end
            default: state_next = ssdf_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready = 1'b0;
        pop      = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            ssdf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ssdf_pkg::ST_SCAN:
            begin
                pop  = !exhausted && cells[0].valid && head_less;
                emit = emit_want && out_free;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next    = count_reg;
        ptr_next      = ptr_reg + CW'(pop);
        fptr_next     = fptr_reg + CW'(issue);
        occ_next      = occ_reg + OW'(inflight_reg) - OW'(pop);
        inflight_next = issue;
        probe_next    = probe_reg;
        last_next     = last_reg;
        have_next     = have_reg;
        stopped_next  = stopped_reg;
        rcount_next   = rcount_reg;
        stop_cfg_next = cfg_we ? cfg_wdata : stop_cfg_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_value_next  = m_value_reg;
        m_index_next  = m_index_reg;

        if (do_load)
        begin
            count_next = count_reg + CW'(1);
        end

        if (do_probe)
        begin
            probe_next = s_tdata;
        end

        if (emit)
        begin
            m_valid_next = 1'b1;
            m_value_next = probe_reg;
            m_index_next = rcount_reg;
            rcount_next  = rcount_reg + ssdf_pkg::INDEX_W'(1);
            last_next    = probe_reg;
            have_next    = 1'b1;
            stopped_next = stop_cfg_reg;
        end

        // A clear drops both sets and the look-ahead state; the store
        // contents and the configuration stay.
        if (do_clear)
        begin
            count_next    = '0;
            ptr_next      = '0;
            fptr_next     = '0;
            occ_next      = '0;
            inflight_next = 1'b0;
            last_next     = '0;
            have_next     = 1'b0;
            stopped_next  = 1'b0;
            rcount_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssdf_pkg::ST_IDLE;
            count_reg    <= '0;
            ptr_reg      <= '0;
            fptr_reg     <= '0;
            occ_reg      <= '0;
            inflight_reg <= 1'b0;
            last_reg     <= '0;
            have_reg     <= 1'b0;
            stopped_reg  <= 1'b0;
            rcount_reg   <= '0;
            stop_cfg_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            fptr_reg     <= fptr_next;
            occ_reg      <= occ_next;
            inflight_reg <= inflight_next;
            last_reg     <= last_next;
            have_reg     <= have_next;
            stopped_reg  <= stopped_next;
            rcount_reg   <= rcount_next;
            stop_cfg_reg <= stop_cfg_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg   <= probe_next;
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_index_reg, m_value_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(WINDOW))
        else $error("look-ahead chain holds more terms than it has cells");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("read pointer ran past the end of the old set");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cells[0].valid && (ptr_reg < count_reg)))
        else $error("pointer advanced without a valid old term at the head");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> (m_value_reg == $past(m_value_reg)))
        else $error("pending result overwritten while stalled");

endmodule
